[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the timer bank RTL.
// All checks sample on the rising edge of clock and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never comes true.
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

[hw/rtl/mtb_pkg.sv]
package mtb_pkg;

   localparam int SLOT_W      = 4;
   localparam int PERIOD_W    = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EVENT  = 1'b1;

   localparam logic STAT_OK      = 1'b0;
   localparam logic STAT_INVALID = 1'b1;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      logic [1:0]          opcode;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      logic                reload;
      logic                reject;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic              kind;
      logic              status;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } rsp_type;

endpackage

[hw/rtl/mtb_ram.sv]
module mtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mtb_fifo.sv]
module mtb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

`include "assert_macros.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // occupancy must agree with the pointer distance
   `ASSERT_NEVER(a_fifo_count_ptrs, (count_ff != '0) && (count_ff != CNT_W'(DEPTH)) && (wr_ptr_ff == rd_ptr_ff), "fifo count disagrees with pointers")

endmodule

[hw/rtl/mtb_front.sv]
module mtb_front #(
   parameter int NUM_SLOTS   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_opcode,
   input  logic [mtb_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic [mtb_pkg::PERIOD_W-1:0]  req_period_length,
   input  logic                          req_reload_mode,
   input  logic                          cmd_pop,
   output mtb_pkg::cmd_type              cmd,
   output logic                          cmd_empty
);

   import mtb_pkg::*;

   cmd_type                  cmd_new;
   logic                     slot_bad;
   logic                     period_zero;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   // classify: out-of-range slot, or zero period after the cut on an init, is marked reject here (ticks never are)
   assign slot_bad    = (32'(req_slot_index) >= 32'(NUM_SLOTS));
   assign period_zero = (COUNT_WIDTH'(req_period_length) == '0);

   always_comb begin
      cmd_new.opcode = req_opcode;
      cmd_new.slot   = req_slot_index;
      cmd_new.period = req_period_length;
      cmd_new.reload = req_reload_mode;
      cmd_new.reject = (req_opcode != OP_TICK) &&
                       (slot_bad || ((req_opcode == OP_INIT) && period_zero));
   end

   mtb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_new),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_bits),
      .empty   (cmd_empty)
   );

   assign cmd = cmd_type'(cmd_bits);

endmodule

[hw/rtl/mtb_engine.sv]
module mtb_engine #(
   parameter int NUM_SLOTS   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  mtb_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             rsp_push,
   output mtb_pkg::rsp_type rsp_data,
   input  logic             rsp_full
);

   import mtb_pkg::*;

`include "assert_macros.svh"

   localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   exe_valid_ff, exe_valid_in;
   logic [SLOT_AW-1:0]     exe_idx_ff, exe_idx_in;
   logic                   held_valid_ff, held_valid_in;
   logic [SLOT_W-1:0]      held_slot_ff, held_slot_in;
   logic [SLOT_W-1:0]      start_slot_ff, start_slot_in;
   logic [NUM_SLOTS-1:0]   running_ff, running_in;
   logic [NUM_SLOTS-1:0]   configured_ff, configured_in;
   logic [NUM_SLOTS-1:0]   periodic_ff, periodic_in;

   logic [SLOT_AW-1:0]     cmd_addr;
   logic [SLOT_AW-1:0]     start_addr;
   logic [COUNT_WIDTH-1:0] period_cut;
   logic                   per_wr;
   logic                   rem_wr;
   logic [SLOT_AW-1:0]     wr_addr;
   logic [COUNT_WIDTH-1:0] rem_wr_data;
   logic                   rd_en;
   logic [SLOT_AW-1:0]     rd_addr;
   logic [COUNT_WIDTH-1:0] per_rd;
   logic [COUNT_WIDTH-1:0] rem_rd;
   logic                   exe_live;
   logic                   exe_expire;
   logic                   walk_done;
   logic                   advance;

   assign cmd_addr   = SLOT_AW'(cmd.slot);
   assign start_addr = SLOT_AW'(start_slot_ff);
   assign period_cut = COUNT_WIDTH'(cmd.period);

   assign exe_live   = exe_valid_ff && running_ff[exe_idx_ff] && (rem_rd != '0);
   assign exe_expire = exe_live && (rem_rd == COUNT_WIDTH'(1));
   assign walk_done  = !exe_valid_ff && (rd_idx_ff == CNT_W'(NUM_SLOTS));
   // the slot in execute may only retire if the held expiry has room to leave
   assign advance    = !(exe_expire && held_valid_ff) || !rsp_full;

   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      exe_valid_in   = exe_valid_ff;
      exe_idx_in     = exe_idx_ff;
      held_valid_in  = held_valid_ff;
      held_slot_in   = held_slot_ff;
      start_slot_in  = start_slot_ff;
      running_in     = running_ff;
      configured_in  = configured_ff;
      periodic_in    = periodic_ff;
      cmd_pop        = 1'b0;
      per_wr         = 1'b0;
      rem_wr         = 1'b0;
      wr_addr        = cmd_addr;
      rem_wr_data    = period_cut;
      rd_en          = 1'b0;
      rd_addr        = cmd_addr;
      rsp_push       = 1'b0;
      rsp_data.kind   = KIND_STATUS;
      rsp_data.status = STAT_OK;
      rsp_data.slot   = cmd.slot;
      rsp_data.last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.opcode == OP_TICK) begin
                  cmd_pop       = 1'b1;
                  rd_idx_in     = '0;
                  exe_valid_in  = 1'b0;
                  held_valid_in = 1'b0;
                  state_in      = S_WALK;
               end else if ((cmd.opcode == OP_START) && !cmd.reject &&
                            configured_ff[cmd_addr]) begin
                  cmd_pop       = 1'b1;
                  rd_en         = 1'b1;
                  start_slot_in = cmd.slot;
                  state_in      = S_START;
               end else if (!rsp_full) begin
                  cmd_pop  = 1'b1;
                  rsp_push = 1'b1;
                  if (cmd.reject || (cmd.opcode == OP_START)) begin
                     // a start that lands here is rejected or addresses a slot never set up
                     rsp_data.status = STAT_INVALID;
                  end else if (cmd.opcode == OP_INIT) begin
                     per_wr                  = 1'b1;
                     rem_wr                  = 1'b1;
                     periodic_in[cmd_addr]   = cmd.reload;
                     running_in[cmd_addr]    = 1'b0;
                     configured_in[cmd_addr] = 1'b1;
                  end else begin
                     running_in[cmd_addr] = 1'b0;
                  end
               end
            end
         end

         S_START: begin
            if (!rsp_full) begin
               rem_wr                 = 1'b1;
               wr_addr                = start_addr;
               rem_wr_data            = per_rd;
               running_in[start_addr] = 1'b1;
               rsp_push               = 1'b1;
               rsp_data.slot          = start_slot_ff;
               state_in               = S_IDLE;
            end
         end

         S_WALK: begin
            rd_addr        = rd_idx_ff[SLOT_AW-1:0];
            rsp_data.kind  = KIND_EVENT;
            rsp_data.slot  = held_slot_ff;
            if (walk_done) begin
               if (!held_valid_ff) begin
                  state_in = S_IDLE;
               end else if (!rsp_full) begin
                  rsp_push      = 1'b1;
                  rsp_data.last = 1'b1;
                  held_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end else if (advance) begin
               if (exe_live) begin
                  rem_wr  = 1'b1;
                  wr_addr = exe_idx_ff;
                  if (exe_expire) begin
                     rem_wr_data = periodic_ff[exe_idx_ff] ? per_rd : '0;
                     if (!periodic_ff[exe_idx_ff]) begin
                        running_in[exe_idx_ff] = 1'b0;
                     end
                     if (held_valid_ff) begin
                        rsp_push      = 1'b1;
                        rsp_data.last = 1'b0;
                     end
                     held_valid_in = 1'b1;
                     held_slot_in  = SLOT_W'(exe_idx_ff);
                  end else begin
                     rem_wr_data = rem_rd - COUNT_WIDTH'(1);
                  end
               end
               if (rd_idx_ff != CNT_W'(NUM_SLOTS)) begin
                  rd_en        = 1'b1;
                  exe_valid_in = 1'b1;
                  exe_idx_in   = rd_idx_ff[SLOT_AW-1:0];
                  rd_idx_in    = rd_idx_ff + CNT_W'(1);
               end else begin
                  exe_valid_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_idx_ff     <= '0;
         exe_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         running_ff    <= '0;
         configured_ff <= '0;
         periodic_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         exe_valid_ff  <= exe_valid_in;
         held_valid_ff <= held_valid_in;
         running_ff    <= running_in;
         configured_ff <= configured_in;
         periodic_ff   <= periodic_in;
      end
   end

   always_ff @(posedge clock) begin
      exe_idx_ff    <= exe_idx_in;
      held_slot_ff  <= held_slot_in;
      start_slot_ff <= start_slot_in;
   end

   mtb_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_SLOTS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (per_wr),
      .wr_addr (wr_addr),
      .wr_data (period_cut),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (per_rd)
   );

   mtb_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_SLOTS)
   ) u_remain_ram (
      .clock   (clock),
      .wr_en   (rem_wr),
      .wr_addr (wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rem_rd)
   );

   `ASSERT_NEVER(a_run_needs_config, (running_ff & ~configured_ff) != '0, "running slot was never set up")
   `ASSERT_NEVER(a_held_only_in_walk, held_valid_ff && (state_ff != S_WALK), "expiry held outside a tick walk")
   `ASSERT_NEVER(a_push_into_full, rsp_push && rsp_full, "result pushed into a full queue")

endmodule

[hw/rtl/multi_timer_bank.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------------
// request   | req_push/req_full  | opcode, slot_index, period_length, reload_mode
// response  | rsp_pop/rsp_empty  | result_kind, status_code, event_slot, last_of_run
//
// Init, stop and rejects are done as they are taken; start reads the period, then writes it.
// A tick walk takes the tick, reads each slot through the remaining-count RAM read port,
// retires the last slot and then flushes the held expiry.
// Synchronous active-high reset clears the slot flags and queues; the count RAMs
// need no clearing pass, since a slot's counts are used only once its flags say it is set up.
// Both sides have a two-entry queue; the walk holds while it must push an expiry into a full result queue.
module multi_timer_bank #(
   parameter int NUM_SLOTS   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_slot_index,
   input  logic [31:0] req_period_length,
   input  logic        req_reload_mode,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_result_kind,
   output logic        rsp_status_code,
   output logic [3:0]  rsp_event_slot,
   output logic        rsp_last_of_run
);

   import mtb_pkg::*;

   cmd_type                    cmd;
   logic                       cmd_empty;
   logic                       cmd_pop;
   logic                       rsp_push;
   logic                       rsp_full;
   rsp_type                    rsp_new;
   logic [$bits(rsp_type)-1:0] rsp_bits;
   rsp_type                    rsp_head;

   // Front end: classify each item (range and zero-period checks) and queue it.
   mtb_front #(
      .NUM_SLOTS   (NUM_SLOTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_slot_index    (req_slot_index),
      .req_period_length (req_period_length),
      .req_reload_mode   (req_reload_mode),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd),
      .cmd_empty         (cmd_empty)
   );

   // Back end: execute commands against the slot state and walk slots on a tick.
   mtb_engine #(
      .NUM_SLOTS   (NUM_SLOTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_new),
      .rsp_full  (rsp_full)
   );

   // Result queue: decouple the engine from the consumer.
   mtb_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_bits),
      .empty   (rsp_empty)
   );

   // Unpack the head item onto the result ports.
   assign rsp_head        = rsp_type'(rsp_bits);
   assign rsp_result_kind = rsp_head.kind;
   assign rsp_status_code = rsp_head.status;
   assign rsp_event_slot  = rsp_head.slot;
   assign rsp_last_of_run = rsp_head.last;

endmodule
